/* sv/color_key_edge_fill_defines.svh */
// assertion macros for the color key edge fill block
// no dependencies; included by the top level
`ifndef COLOR_KEY_EDGE_FILL_DEFINES_SVH
`define COLOR_KEY_EDGE_FILL_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CKE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cke assertion failed");

// next-cycle implication, checked outside reset
`define CKE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cke assertion failed");

`endif

/* sv/cke_pkg.sv */
// shared types and constants for the color key edge fill block
// no dependencies; used by front, back and top level
package cke_pkg;

    localparam int PIX_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [PIX_W-1:0] KEY_RESET = 32'hFF00_FFFF;

    // what the back end has to do with one queued transaction
    typedef struct packed {
        logic emit;
        logic store;
        logic has_left;
        logic has_right;
        logic has_top;
        logic has_below;
        logic frame_end;
    } cke_flags_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RD_RIGHT,
        BK_CALC,
        BK_OUT
    } back_state_t;

    // floor(sum / n) for n in 1..4, sum of up to four 8-bit channels
    function automatic logic [7:0] div_by_count(input logic [9:0] s, input logic [2:0] n);
        logic [20:0] prod;
        logic [7:0]  q;
        prod = {11'd0, s} * 21'd683;
        case (n)
            3'd1:    q = s[7:0];
            3'd2:    q = s[8:1];
            3'd3:    q = prod[18:11];
            default: q = s[9:2];
        endcase
        return q;
    endfunction

endpackage

/* sv/cke_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module cke_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/cke_front.sv */
// front end: accepts transactions, tracks positions and fill, classifies work
// depends on cke_pkg
module cke_front #(
    parameter int AW = 10,
    parameter int WW = 11,
    parameter int HW = 13,
    parameter int RW = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    flush,
    input  logic [WW-1:0]           width,
    input  logic [HW-1:0]           height,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    s_action,
    input  logic [cke_pkg::PIX_W-1:0] s_pixel,
    input  logic                    q_full,
    output logic                    q_push,
    output cke_pkg::cke_flags_t     q_flags,
    output logic [cke_pkg::PIX_W-1:0] q_pixel,
    output logic [AW-1:0]           q_x,
    output logic [AW-1:0]           q_wcol
);
    import cke_pkg::*;

    logic [AW-1:0] in_col_reg, in_col_next;
    logic [WW-1:0] pending_reg, pending_next;
    logic [AW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    logic acc, full, emit, col_last, row_last;

    always_comb begin
        acc      = s_tvalid && !q_full;
        full     = (pending_reg == width);
        emit     = s_action ? (pending_reg != '0) : full;
        col_last = (32'(out_col_reg) + 32'd1 >= 32'(width));
        row_last = (32'(out_row_reg) + 32'd1 >= 32'(height));

        q_flags.emit      = emit;
        q_flags.store     = !s_action;
        q_flags.has_left  = (out_col_reg != '0);
        q_flags.has_right = !col_last && (32'(pending_reg) >= 32'd2);
        q_flags.has_top   = (out_row_reg != '0);
        q_flags.has_below = !s_action && !row_last;
        q_flags.frame_end = col_last && row_last;
        q_push  = acc && (emit || !s_action);
        q_pixel = s_pixel;
        q_x     = out_col_reg;
        q_wcol  = in_col_reg;

        in_col_next  = in_col_reg;
        pending_next = pending_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (acc) begin
            if (!s_action) begin
                in_col_next = (32'(in_col_reg) + 32'd1 >= 32'(width)) ? '0 : in_col_reg + 1'b1;
                if (!full) begin
                    pending_next = pending_reg + 1'b1;
                end
            end else if (pending_reg != '0) begin
                pending_next = pending_reg - 1'b1;
            end
            if (emit) begin
                if (col_last) begin
                    out_col_next = '0;
                    out_row_next = row_last ? '0 : out_row_reg + 1'b1;
                end else begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
        if (flush) begin
            in_col_next  = '0;
            pending_next = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    assign s_tready = !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            pending_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            pending_reg <= pending_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

/* sv/cke_queue.sv */
// two-entry queue between front and back end
// no dependencies
module cke_queue #(
    parameter int WIDTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = mem_reg[rd_ptr_reg];
    assign full      = (count_reg == 2'd2);
    assign empty     = (count_reg == 2'd0);

endmodule

/* sv/cke_back.sv */
// back end: line stores, neighbor average and output register
// depends on cke_pkg and cke_ram
module cke_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [cke_pkg::PIX_W-1:0] key,
    input  logic                      q_valid,
    input  cke_pkg::cke_flags_t       q_flags,
    input  logic [cke_pkg::PIX_W-1:0] q_pixel,
    input  logic [AW-1:0]             q_x,
    input  logic [AW-1:0]             q_wcol,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,
    output logic                      m_tlast
);
    import cke_pkg::*;

    back_state_t state_reg, state_next;

    logic [PIX_W-1:0] orig_reg, top_reg, left_reg, result_reg, result_next;
    logic [31:0]      m_data_reg;
    logic             m_last_reg, m_valid_reg;

    logic             raw_we, done_we, can_load;
    logic [AW-1:0]    raw_raddr;
    logic [PIX_W-1:0] raw_rd, done_rd;

    logic             ok_l, ok_r, ok_t, ok_b;
    logic [2:0]       n;
    logic [9:0]       sum_r, sum_g, sum_b;

    cke_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_raw_line (
        .clk(aclk), .we(raw_we), .waddr(q_wcol), .wdata(q_pixel),
        .raddr(raw_raddr), .rdata(raw_rd)
    );

    cke_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_done_line (
        .clk(aclk), .we(done_we), .waddr(q_x), .wdata(result_reg),
        .raddr(q_x), .rdata(done_rd)
    );

    // neighbor average, right neighbor comes straight off the raw line read
    always_comb begin
        ok_l = q_flags.has_left  && (left_reg != key);
        ok_r = q_flags.has_right && (raw_rd   != key);
        ok_t = q_flags.has_top   && (top_reg  != key);
        ok_b = q_flags.has_below && (q_pixel  != key);
        n = {2'b0, ok_l} + {2'b0, ok_r} + {2'b0, ok_t} + {2'b0, ok_b};
        sum_r = (ok_l ? {2'b0, left_reg[23:16]} : 10'd0) + (ok_r ? {2'b0, raw_rd[23:16]} : 10'd0)
              + (ok_t ? {2'b0, top_reg[23:16]}  : 10'd0) + (ok_b ? {2'b0, q_pixel[23:16]} : 10'd0);
        sum_g = (ok_l ? {2'b0, left_reg[15:8]} : 10'd0) + (ok_r ? {2'b0, raw_rd[15:8]} : 10'd0)
              + (ok_t ? {2'b0, top_reg[15:8]}  : 10'd0) + (ok_b ? {2'b0, q_pixel[15:8]} : 10'd0);
        sum_b = (ok_l ? {2'b0, left_reg[7:0]} : 10'd0) + (ok_r ? {2'b0, raw_rd[7:0]} : 10'd0)
              + (ok_t ? {2'b0, top_reg[7:0]}  : 10'd0) + (ok_b ? {2'b0, q_pixel[7:0]} : 10'd0);
        if (orig_reg != key) begin
            result_next = orig_reg;
        end else if (n == 3'd0) begin
            result_next = '0;
        end else begin
            result_next = {8'd0, div_by_count(sum_r, n), div_by_count(sum_g, n),
                           div_by_count(sum_b, n)};
        end
    end

    always_comb begin
        state_next = state_reg;
        can_load   = !m_valid_reg || m_tready;
        raw_raddr  = (state_reg == BK_IDLE) ? q_x : q_x + 1'b1;
        raw_we     = 1'b0;
        done_we    = 1'b0;
        q_pop      = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    if (q_flags.emit) begin
                        state_next = BK_RD_RIGHT;
                    end else begin
                        raw_we = q_flags.store;
                        q_pop  = 1'b1;
                    end
                end
            end
            BK_RD_RIGHT: state_next = BK_CALC;
            BK_CALC:     state_next = BK_OUT;
            BK_OUT: begin
                if (can_load) begin
                    raw_we     = q_flags.store;
                    done_we    = 1'b1;
                    q_pop      = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == BK_OUT && can_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == BK_RD_RIGHT) begin
            orig_reg <= raw_rd;
            top_reg  <= done_rd;
        end
        if (state_reg == BK_CALC) begin
            result_reg <= result_next;
        end
        if (state_reg == BK_OUT && can_load) begin
            left_reg   <= result_reg;
            m_data_reg <= {result_reg[7:0], result_reg[15:8], result_reg[23:16],
                           result_reg[31:24]};
            m_last_reg <= q_flags.frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* sv/color_key_edge_fill.sv */
// color key edge fill: a pixel of the key color becomes transparent, neighbor average
// order: a result leaves frame_width transactions after its pixel; m_tvalid rises once the
// releasing transaction has passed the queue and the back end states; an emitting one steps
// through idle, right read, average and output (two reads of the raw line over one ram port),
// waiting in output for a free output register; one that only stores is popped in idle
// reset: synchronous active-low aresetn clears positions, fill count, queue and output;
// line stores are not cleared, key and sizes return to their reset values
`include "color_key_edge_fill_defines.svh"

module color_key_edge_fill #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // alpha_in, red_in, green_in, blue_in
    input  logic                           s_tuser,   // action
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // alpha_out, red_out, green_out, blue_out
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cke_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cke_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cke_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int FW = $bits(cke_flags_t);
    localparam int QW = FW + PIX_W + 2 * AW;

    logic [PIX_W-1:0] key_reg;
    logic [WW-1:0]    width_reg;
    logic [HW-1:0]    height_reg;
    logic             cfg_wr, flush;
    logic [CFG_WIDTH_W-1:0]  w_val;
    logic [CFG_HEIGHT_W-1:0] h_val;

    logic             q_push, q_pop, q_full, q_empty;
    cke_flags_t       f_flags, b_flags;
    logic [PIX_W-1:0] f_pixel, b_pixel, s_pixel;
    logic [AW-1:0]    f_x, f_wcol, b_x, b_wcol;
    logic [QW-1:0]    q_head;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign flush     = cfg_wr && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);
    assign w_val     = cfg_data[CFG_WIDTH_W-1:0];
    assign h_val     = cfg_data[CFG_HEIGHT_W-1:0];
    assign s_pixel   = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg    <= KEY_RESET;
            width_reg  <= WW'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
            height_reg <= HW'(1);
        end else if (cfg_wr) begin
            if (cfg_index == CFG_KEY) begin
                key_reg <= cfg_data[PIX_W-1:0];
            end else if (cfg_index == CFG_WIDTH) begin
                if (w_val == '0) begin
                    width_reg <= WW'(1);
                end else if (32'(w_val) > MAX_WIDTH) begin
                    width_reg <= WW'(MAX_WIDTH);
                end else begin
                    width_reg <= WW'(w_val);
                end
            end else if (cfg_index == CFG_HEIGHT) begin
                if (h_val == '0) begin
                    height_reg <= HW'(1);
                end else if (32'(h_val) > MAX_HEIGHT) begin
                    height_reg <= HW'(MAX_HEIGHT);
                end else begin
                    height_reg <= HW'(h_val);
                end
            end
        end
    end

    cke_front #(.AW(AW), .WW(WW), .HW(HW), .RW(RW)) u_front (
        .aclk(aclk), .aresetn(aresetn), .flush(flush),
        .width(width_reg), .height(height_reg),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_action(s_tuser), .s_pixel(s_pixel),
        .q_full(q_full), .q_push(q_push), .q_flags(f_flags), .q_pixel(f_pixel),
        .q_x(f_x), .q_wcol(f_wcol)
    );

    cke_queue #(.WIDTH(QW)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data({f_flags, f_pixel, f_x, f_wcol}),
        .pop(q_pop), .head_data(q_head), .full(q_full), .empty(q_empty)
    );

    assign {b_flags, b_pixel, b_x, b_wcol} = q_head;

    cke_back #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_back (
        .aclk(aclk), .aresetn(aresetn), .key(key_reg),
        .q_valid(!q_empty), .q_flags(b_flags), .q_pixel(b_pixel), .q_x(b_x),
        .q_wcol(b_wcol), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    `CKE_ASSERT_IMP(a_push_not_full, aclk, aresetn, q_push, !q_full)
    `CKE_ASSERT_IMP(a_pop_not_empty, aclk, aresetn, q_pop, !q_empty)
    `CKE_ASSERT_NEXT(a_push_fills, aclk, aresetn, q_push && !q_pop, !q_empty)
    `CKE_ASSERT_IMP(a_result_from_pop, aclk, aresetn, $rose(m_tvalid), $past(q_pop))

endmodule

/* bench/testbench.sv */
// testbench for the color key edge fill block: directed and random pixel frames
// predicts each output pixel with its own line-buffer model; needs cke_pkg and the rtl
`timescale 1ns / 100ps

module testbench;
    import cke_pkg::*;

    localparam int LINE_MAX   = 1024;
    localparam int HEIGHT_MAX = 4096;
    localparam int HOLD_LEN   = 300;

    typedef struct {
        logic [31:0] pix;   // argb
        logic        last;
    } out_pixel_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    color_key_edge_fill DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    logic [31:0] key_color;
    int          frame_w;
    int          frame_h;
    logic [31:0] raw_line  [LINE_MAX];
    logic [31:0] done_line [LINE_MAX];
    int          in_pos;
    int          out_col;
    int          out_row;
    int          held_count;

    out_pixel_t  expected_pixels [$];
    int          error_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_requests;
    int          hold_served;
    int          hold_left;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    function automatic bit is_neighbor(input logic [31:0] p);
        return p != key_color;
    endfunction

    // oldest held pixel leaves; below is the bottom neighbor when has_below is set
    task automatic emit_oldest(input bit has_below, input logic [31:0] below);
        int x, y, n, r, g, b;
        logic [31:0] orig, res;
        logic [31:0] nb [4];
        out_pixel_t  e;
        x = out_col;
        y = out_row;
        orig = raw_line[x];
        res = orig;
        if (orig == key_color) begin
            n = 0;
            if (x > 0 && is_neighbor(done_line[x-1])) begin
                nb[n] = done_line[x-1];
                n++;
            end
            if (x + 1 < frame_w && held_count >= 2 && is_neighbor(raw_line[x+1])) begin
                nb[n] = raw_line[x+1];
                n++;
            end
            if (y > 0 && is_neighbor(done_line[x])) begin
                nb[n] = done_line[x];
                n++;
            end
            if (has_below && y + 1 < frame_h && is_neighbor(below)) begin
                nb[n] = below;
                n++;
            end
            if (n == 0) begin
                res = 32'd0;
            end else begin
                r = 0;
                g = 0;
                b = 0;
                for (int i = 0; i < n; i++) begin
                    r += nb[i][23:16];
                    g += nb[i][15:8];
                    b += nb[i][7:0];
                end
                res = {8'd0, 8'(r / n), 8'(g / n), 8'(b / n)};
            end
        end
        done_line[x] = res;
        e.pix = res;
        e.last = (x + 1 == frame_w) && (y + 1 == frame_h);
        expected_pixels = {expected_pixels, e};
        out_col = x + 1;
        if (out_col >= frame_w) begin
            out_col = 0;
            out_row = y + 1;
            if (out_row >= frame_h) out_row = 0;
        end
    endtask

    task automatic predict_fill(input bit drain, input logic [31:0] px);
        if (!drain) begin
            if (held_count >= frame_w) emit_oldest(1'b1, px);
            else held_count++;
            raw_line[in_pos % frame_w] = px;
            in_pos++;
            if (in_pos >= frame_w * frame_h) in_pos = 0;
        end else if (held_count > 0) begin
            emit_oldest(1'b0, 32'd0);
            held_count--;
        end
    endtask

    function automatic int clamp_size(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // one pixel or drain transaction; valid stays high for back-to-back items
    task automatic send_item(input bit drain, input logic [31:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= drain;
        s_tdata  <= {px[7:0], px[15:8], px[23:16], px[31:24]};
        do @(posedge aclk); while (!s_tready);
        predict_fill(drain, px);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_KEY) begin
            key_color = val;
        end else if (idx == CFG_WIDTH) begin
            frame_w = clamp_size(int'(val[10:0]), LINE_MAX);
        end else begin
            frame_h = clamp_size(int'(val[12:0]), HEIGHT_MAX);
        end
        if (idx != CFG_KEY) begin
            in_pos = 0;
            out_col = 0;
            out_row = 0;
            held_count = 0;
        end
    endtask

    task automatic setup_frame(input int w, input int h, input logic [31:0] key);
        wait_idle();
        write_reg(CFG_KEY, key);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    task automatic drain_all(input int n);
        for (int i = 0; i < n; i++) send_item(1'b1, 32'd0);
    endtask

    // the key with probability key_pct, otherwise extremes, near-key or random colors
    function automatic logic [31:0] pick_pixel(input int key_pct);
        int sel;
        sel = $urandom_range(99);
        if (sel < key_pct) return key_color;
        sel = $urandom_range(9);
        if (sel == 0) return 32'hFFFF_FFFF;
        if (sel == 1) return 32'h0000_0000;
        if (sel == 2) return key_color ^ (32'd1 << $urandom_range(31));
        return $urandom;
    endfunction

    // keyed corners, edges, a fully keyed row and saturated neighbors
    task automatic test_small_frame();
        logic [31:0] k;
        k = 32'h12AB_CD34;
        setup_frame(3, 3, k);
        send_item(1'b1, 32'd0);   // drain with nothing held
        send_item(1'b0, k);
        send_item(1'b0, 32'hFFFF_FFFF);
        send_item(1'b0, k);
        send_item(1'b0, k);
        send_item(1'b0, k);
        send_item(1'b0, k);
        send_item(1'b0, 32'h00FF_FFFF);
        send_item(1'b0, k);
        send_item(1'b0, 32'h8001_0203);
        drain_all(3);
    endtask

    // widest line with a few pixels, then out-of-range sizes that saturate
    task automatic test_size_extremes();
        setup_frame(2047, 8191, 32'h0000_0000);
        send_item(1'b0, 32'h0000_0000);
        send_item(1'b0, 32'h00FE_FDFC);
        send_item(1'b0, 32'h0000_0000);
        send_item(1'b0, 32'h0000_0000);
        drain_all(5);
        setup_frame(0, 0, 32'hFFFF_FFFF);
        send_item(1'b0, 32'hFFFF_FFFF);
        send_item(1'b0, 32'h7F00_00FF);
        send_item(1'b0, 32'hFFFF_FFFF);
        drain_all(2);
    endtask

    // frames of random sizes; some skip the drain or drain mid frame
    task automatic test_random_frames(input int items);
        int sent, w, h, key_pct, mode, n_drain;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(9) == 0) w = $urandom_range(9, 24);
            else w = $urandom_range(1, 8);
            h = $urandom_range(1, 5);
            if ($urandom_range(3) == 0) key_pct = 70;
            else key_pct = $urandom_range(10, 45);
            setup_frame(w, h, $urandom_range(1) ? $urandom : 32'hFF00_FFFF);
            mode = $urandom_range(9);
            for (int f = 0; f < (mode < 3 ? 2 : 1); f++) begin
                for (int i = 0; i < w * h; i++) begin
                    if (mode == 9 && $urandom_range(15) == 0) begin
                        send_item(1'b1, $urandom);
                        sent++;
                    end
                    send_item(1'b0, pick_pixel(key_pct));
                    sent++;
                end
            end
            if (mode != 8) begin
                n_drain = w + $urandom_range(1) * $urandom_range(2);
                drain_all(n_drain);
                sent += n_drain;
            end
        end
    endtask

    // receiver: stalls, long hold-offs and checking
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served < hold_requests) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_served <= hold_served + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                report("unexpected transaction", m_tdata, 32'd0);
            end else begin
                out_pixel_t e;
                e = expected_pixels.pop_front();
                if (m_tdata[7:0] != e.pix[31:24]) report("alpha", m_tdata[7:0], e.pix[31:24]);
                if (m_tdata[15:8] != e.pix[23:16]) report("red", m_tdata[15:8], e.pix[23:16]);
                if (m_tdata[23:16] != e.pix[15:8]) report("green", m_tdata[23:16], e.pix[15:8]);
                if (m_tdata[31:24] != e.pix[7:0]) report("blue", m_tdata[31:24], e.pix[7:0]);
                if (m_tlast != e.last) report("frame end", m_tlast, e.last);
            end
        end
    end

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_KEY;
        cfg_data = '0;
        aresetn = 1'b0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        key_color = KEY_RESET;
        frame_w = LINE_MAX;
        frame_h = 1;
        in_pos = 0;
        out_col = 0;
        out_row = 0;
        held_count = 0;
        for (int i = 0; i < LINE_MAX; i++) begin
            raw_line[i] = '0;
            done_line[i] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_small_frame();
        test_size_extremes();

        test_random_frames(260);
        send_idle_pct = 53;
        test_random_frames(260);
        send_idle_pct = 0;
        recv_stall_pct = 53;
        test_random_frames(260);
        send_idle_pct = 19;
        recv_stall_pct = 19;
        // long receiver hold-off while pixels keep coming
        setup_frame(8, 5, 32'h00FF_00FF);
        hold_requests = 1;
        for (int i = 0; i < 40; i++) send_item(1'b0, pick_pixel(40));
        drain_all(8);
        test_random_frames(220);

        wait_idle();
        repeat (30) @(posedge aclk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/cke_pkg.sv
sv/cke_ram.sv
sv/cke_front.sv
sv/cke_queue.sv
sv/cke_back.sv
sv/color_key_edge_fill.sv
bench/testbench.sv
